FILE: rtl/assert_macros.svh
// Assertion macros shared by the seed hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/csh_pkg.sv
// Constants and types shared by the seed hasher modules.
package csh_pkg;

  // Mixer constants
  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;
  localparam logic [63:0] SEED_SALT    = 64'hD1B54A32D192ED03;

  localparam logic [31:0] MUL_A_LO = MIX_MUL_A[31:0];
  localparam logic [31:0] MUL_A_HI = MIX_MUL_A[63:32];
  localparam logic [31:0] MUL_B_LO = MIX_MUL_B[31:0];
  localparam logic [31:0] MUL_B_HI = MIX_MUL_B[63:32];

  // Pipeline geometry
  localparam int NUM_WORDS = 6;
  localparam int MIX_LAT   = 5;
  localparam int CELL_LAT  = MIX_LAT + 1;

  // Configuration register indexes
  localparam logic [1:0] REG_WORLD_SEED = 2'd0;
  localparam logic [1:0] REG_COUNT_MIN  = 2'd1;
  localparam logic [1:0] REG_COUNT_MAX  = 2'd2;

  // Work carried down the cell chain: words still to be folded, lowest first
  typedef struct packed {
    logic                           body;
    logic [NUM_WORDS-1:0][63:0]     words;
  } job_t;

endpackage

FILE: rtl/csh_mix.sv
// Pipelined splitmix64 finalizer, five register stages, no stall.
module csh_mix (
  input  logic        clk,
  input  logic [63:0] din,
  output logic [63:0] dout
);

  logic [63:0] a_sum;
  logic [63:0] s0;
  logic [63:0] p0a;
  logic [31:0] p1a;
  logic [31:0] p2a;
  logic [63:0] y;
  logic [63:0] s2;
  logic [63:0] p0b;
  logic [31:0] p1b;
  logic [31:0] p2b;
  logic [63:0] w;

  // Add gamma, then first xor-shift
  assign a_sum = din + csh_pkg::GOLDEN_GAMMA;

  // Recombine first product (mod 2^64)
  assign y = p0a + {p1a + p2a, 32'd0};

  // Recombine second product
  assign w = p0b + {p1b + p2b, 32'd0};

  always_ff @(posedge clk) begin
    s0   <= a_sum ^ (a_sum >> 30);
    // partial products of s0 * MUL_A
    p0a  <= s0[31:0] * csh_pkg::MUL_A_LO;
    p1a  <= s0[63:32] * csh_pkg::MUL_A_LO;
    p2a  <= s0[31:0] * csh_pkg::MUL_A_HI;
    s2   <= y ^ (y >> 27);
    // partial products of s2 * MUL_B
    p0b  <= s2[31:0] * csh_pkg::MUL_B_LO;
    p1b  <= s2[63:32] * csh_pkg::MUL_B_LO;
    p2b  <= s2[31:0] * csh_pkg::MUL_B_HI;
    dout <= w ^ (w >> 31);
  end

endmodule

FILE: rtl/csh_fold_cell.sv
// One combine cell: folds the lowest pending word into the running hash.
module csh_fold_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       in_hash,
  input  csh_pkg::job_t     in_job,
  output logic              out_valid,
  output logic [63:0]       out_hash,
  output csh_pkg::job_t     out_job
);

  logic [63:0]   comb_hash;
  logic [63:0]   comb_sum;
  logic [csh_pkg::CELL_LAT-1:0] vld;
  csh_pkg::job_t job_pipe [csh_pkg::CELL_LAT];
  csh_pkg::job_t job_shift;

  // h ^ (mix(v) + gamma + (h << 6) + (h >> 2))
  assign comb_sum = in_job.words[0] + csh_pkg::GOLDEN_GAMMA + (in_hash << 6) + (in_hash >> 2);

  // Drop the consumed word so the next cell sees its word at the bottom
  always_comb begin
    job_shift       = in_job;
    job_shift.words = in_job.words >> 64;
  end

  always_ff @(posedge clk) begin
    comb_hash <= in_hash ^ comb_sum;
  end

  // Valid and job ride alongside the mixer
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[csh_pkg::CELL_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    job_pipe[0] <= job_shift;
    for (int i = 1; i < csh_pkg::CELL_LAT; i++) begin
      job_pipe[i] <= job_pipe[i-1];
    end
  end

  csh_mix u_mix (
    .clk  (clk),
    .din  (comb_hash),
    .dout (out_hash)
  );

  assign out_valid = vld[csh_pkg::CELL_LAT-1];
  assign out_job   = job_pipe[csh_pkg::CELL_LAT-1];

endmodule

FILE: rtl/coordinate_seed_hasher_top.sv
// Top level of the coordinate seed hasher: lane mixers, fold cell chain, count scaler.
// done pulses once an accepted start has passed the lane mixers, fold cells and scale stages.
// Throughput: one word per cycle; busy stays low, the fully pipelined mixer chain never stalls.
// Results cannot be held off; each shows on the result ports for one cycle with done.
// Reset (rst, synchronous): clears the pipeline valids and sets all three registers to zero.
`include "assert_macros.svh"

module coordinate_seed_hasher_top (
  input  logic        clk,
  input  logic        rst,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [63:0] sector_x,
  input  logic [63:0] sector_y,
  input  logic [63:0] sector_z,
  input  logic [7:0]  family,
  input  logic [31:0] object_index,
  input  logic [31:0] property_req,
  // result side
  output logic        done,
  output logic [63:0] hash_value,
  output logic [52:0] unit_fraction,
  output logic signed [31:0] body_count,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int NW = csh_pkg::NUM_WORDS;

  logic        accept;
  logic [63:0] world_seed;
  logic [31:0] count_min;
  logic [31:0] count_max;

  logic [NW-1:0][63:0] in_words;
  logic [NW-1:0][63:0] lane_out;
  logic [63:0]         seed_mixed;
  logic [csh_pkg::MIX_LAT-1:0] lane_vld;
  logic [csh_pkg::MIX_LAT-1:0] lane_body;

  logic          cell_valid [NW+1];
  logic [63:0]   cell_hash  [NW+1];
  csh_pkg::job_t cell_job   [NW+1];

  logic [32:0] span_diff;
  logic [32:0] span_q;
  logic        empty_q;

  logic        m1_valid;
  logic        m1_body;
  logic [63:0] m1_hash;
  logic [63:0] m1_a;
  logic [53:0] m1_b;
  logic [63:0] q_sum;
  logic [31:0] scaled;
  logic [31:0] empty_count;
  logic        out_body;

  assign accept    = start && !busy;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      world_seed <= '0;
      count_min  <= '0;
      count_max  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        csh_pkg::REG_WORLD_SEED: world_seed <= cfg_data;
        csh_pkg::REG_COUNT_MIN:  count_min  <= cfg_data[31:0];
        csh_pkg::REG_COUNT_MAX:  count_max  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Words to fold; body-count mode forces index to all ones and property to zero
  always_comb begin
    in_words[0] = sector_x;
    in_words[1] = sector_y;
    in_words[2] = sector_z;
    in_words[3] = {56'd0, family};
    in_words[4] = action ? 64'h0000_0000_FFFF_FFFF : {32'd0, object_index};
    in_words[5] = action ? 64'd0 : {32'd0, property_req};
  end

  // Lane mixers: seed and all six words mixed side by side
  csh_mix u_seed_mix (
    .clk  (clk),
    .din  (world_seed ^ csh_pkg::SEED_SALT),
    .dout (seed_mixed)
  );

  for (genvar g = 0; g < NW; g++) begin : g_lane
    csh_mix u_lane_mix (
      .clk  (clk),
      .din  (in_words[g]),
      .dout (lane_out[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_vld <= '0;
    end else begin
      lane_vld <= {lane_vld[csh_pkg::MIX_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    lane_body <= {lane_body[csh_pkg::MIX_LAT-2:0], action};
  end

  assign cell_valid[0]     = lane_vld[csh_pkg::MIX_LAT-1];
  assign cell_hash[0]      = seed_mixed;
  assign cell_job[0].body  = lane_body[csh_pkg::MIX_LAT-1];
  assign cell_job[0].words = lane_out;

  // Fold chain: one cell per word
  for (genvar c = 0; c < NW; c++) begin : g_cell
    csh_fold_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_valid[c]),
      .in_hash   (cell_hash[c]),
      .in_job    (cell_job[c]),
      .out_valid (cell_valid[c+1]),
      .out_hash  (cell_hash[c+1]),
      .out_job   (cell_job[c+1])
    );
  end

  // Span and empty-range flag, refreshed from the registers every cycle
  assign span_diff = {count_max[31], count_max} - {count_min[31], count_min};

  always_ff @(posedge clk) begin
    span_q  <= span_diff + 33'd1;
    empty_q <= $signed(count_max) <= $signed(count_min);
  end

  // Scale stage 1: split-fraction products
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= cell_valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    m1_body <= cell_job[NW].body;
    m1_hash <= cell_hash[NW];
    m1_a    <= cell_hash[NW][63:32] * span_q;
    m1_b    <= cell_hash[NW][31:11] * span_q;
  end

  // Scale stage 2: floor(frac * span / 2^53) plus the low bound
  assign q_sum       = m1_a + {31'd0, m1_b[53:21]};
  assign scaled      = count_min + q_sum[63:32];
  assign empty_count = ($signed(count_min) > 0) ? count_min : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_body      <= m1_body;
    hash_value    <= m1_hash;
    unit_fraction <= m1_hash[63:11];
    if (!m1_body) begin
      body_count <= '0;
    end else if (empty_q) begin
      body_count <= empty_count;
    end else begin
      body_count <= scaled;
    end
  end

  // Checks
  `CSH_ASSERT_IMPLY(a_hash_mode_zero, clk, rst, done && !out_body,
                    body_count == 32'sd0, "hash mode gave a nonzero count")
  `CSH_ASSERT_IMPLY(a_fraction_match, clk, rst, done,
                    unit_fraction == hash_value[63:11], "fraction does not match hash")
  `CSH_ASSERT_NEXT(a_done_follows, clk, rst, m1_valid, done,
                   "finished word lost in scaler")

endmodule

FILE: bench/tb.sv
// Self-checking bench for coordinate_seed_hasher_top: queued commands, predicted hashes.
`timescale 1ns / 100ps

module tb;

  localparam logic ACT_HASH = 1'b0;
  localparam logic ACT_BODY = 1'b1;

  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic [63:0]        S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0]        S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam int PHASES         = 11;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int DRAIN_CYCLES   = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  // one command word
  typedef struct {
    logic        act;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [7:0]  fam;
    logic [31:0] obj_index;
    logic [31:0] prop;
  } sector_query_t;

  // one result word
  typedef struct {
    logic [63:0]        hash;
    logic [52:0]        frac;
    logic signed [31:0] count;
  } seed_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        start        = 1'b0;
  logic        busy;
  logic        action       = 1'b0;
  logic [63:0] sector_x     = '0;
  logic [63:0] sector_y     = '0;
  logic [63:0] sector_z     = '0;
  logic [7:0]  family       = '0;
  logic [31:0] object_index = '0;
  logic [31:0] property_req = '0;
  logic        done;
  logic [63:0] hash_value;
  logic [52:0] unit_fraction;
  logic signed [31:0] body_count;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index    = '0;
  logic [63:0] cfg_data     = '0;

  // register shadow used by the predictor
  logic [63:0]        seed_cfg = '0;
  logic signed [31:0] min_cfg  = '0;
  logic signed [31:0] max_cfg  = '0;

  sector_query_t sector_queries[$];
  seed_result_t  hashes_due[$];
  int            failures = 0;

  coordinate_seed_hasher_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .sector_x     (sector_x),
    .sector_y     (sector_y),
    .sector_z     (sector_z),
    .family       (family),
    .object_index (object_index),
    .property_req (property_req),
    .done         (done),
    .hash_value   (hash_value),
    .unit_fraction(unit_fraction),
    .body_count   (body_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // splitmix64 finalizer
  function automatic logic [63:0] splitmix(input logic [63:0] v);
    logic [63:0] z;
    z = v + csh_pkg::GOLDEN_GAMMA;
    z = (z ^ (z >> 30)) * csh_pkg::MIX_MUL_A;
    z = (z ^ (z >> 27)) * csh_pkg::MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  // combine step followed by a remix
  function automatic logic [63:0] fold_word(input logic [63:0] h, input logic [63:0] v);
    return splitmix(h ^ (splitmix(v) + csh_pkg::GOLDEN_GAMMA + (h << 6) + (h >> 2)));
  endfunction

  function automatic seed_result_t hash_query(input sector_query_t q);
    logic [63:0]        h;
    logic [63:0]        idx_word;
    logic [63:0]        prop_word;
    logic signed [33:0] lo_w;
    logic signed [33:0] hi_w;
    logic signed [33:0] span;
    logic [85:0]        scaled;
    seed_result_t       r;
    // body-count mode hashes a fixed index and property
    idx_word  = (q.act == ACT_BODY) ? 64'h0000_0000_FFFF_FFFF : {32'd0, q.obj_index};
    prop_word = (q.act == ACT_BODY) ? 64'd0 : {32'd0, q.prop};
    h = splitmix(seed_cfg ^ csh_pkg::SEED_SALT);
    h = fold_word(h, q.x);
    h = fold_word(h, q.y);
    h = fold_word(h, q.z);
    h = fold_word(h, {56'd0, q.fam});
    h = fold_word(h, idx_word);
    h = fold_word(h, prop_word);
    r.hash  = h;
    r.frac  = h[63:11];
    r.count = '0;
    if (q.act == ACT_BODY) begin
      if (max_cfg <= min_cfg) begin
        // empty range: clamp the minimum at zero
        r.count = (min_cfg > 0) ? min_cfg : 32'sd0;
      end else begin
        // exact scaling: span up to 2^32, product held in 86 bits
        lo_w   = min_cfg;
        hi_w   = max_cfg;
        span   = hi_w - lo_w + 34'sd1;
        scaled = r.frac * span[32:0];
        r.count = min_cfg + scaled[84:53];
      end
    end
    return r;
  endfunction

  function automatic sector_query_t make_query(input logic act, input logic [63:0] x,
                                               input logic [63:0] y, input logic [63:0] z,
                                               input logic [7:0] fam,
                                               input logic [31:0] obj_index,
                                               input logic [31:0] prop);
    sector_query_t q;
    q.act       = act;
    q.x         = x;
    q.y         = y;
    q.z         = z;
    q.fam       = fam;
    q.obj_index = obj_index;
    q.prop      = prop;
    return q;
  endfunction

  // coordinates: mostly full range, some near the origin, some extremes
  function automatic logic [63:0] rand_coord();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      3, 4: v = longint'($urandom_range(0, 2000)) - 64'sd1000;
      5: begin
        case ($urandom_range(0, 3))
          0: v = S64_MIN;
          1: v = S64_MAX;
          2: v = '1;
          default: v = '0;
        endcase
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_u32();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 15);
      1: v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic sector_query_t rand_query();
    return make_query($urandom_range(0, 1) ? ACT_BODY : ACT_HASH, rand_coord(),
                      rand_coord(), rand_coord(), 8'($urandom_range(0, 255)),
                      rand_u32(), rand_u32());
  endfunction

  // write the selected registers back to back over the config channel
  task automatic program_regs(input logic [63:0] seed, input logic [31:0] lo,
                              input logic [31:0] hi, input logic [2:0] mask);
    logic [1:0]  idx [3];
    logic [63:0] val [3];
    bit          raised;
    idx = '{csh_pkg::REG_WORLD_SEED, csh_pkg::REG_COUNT_MIN, csh_pkg::REG_COUNT_MAX};
    // upper data bits of the count registers are junk and must be dropped
    val = '{seed, {$urandom, lo}, {$urandom, hi}};
    raised = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (mask[i]) begin
        cfg_index <= idx[i];
        cfg_data  <= val[i];
        if (!raised) cfg_valid <= 1'b1;
        raised = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx[i])
          csh_pkg::REG_WORLD_SEED: seed_cfg = val[i];
          csh_pkg::REG_COUNT_MIN:  min_cfg  = val[i][31:0];
          csh_pkg::REG_COUNT_MAX:  max_cfg  = val[i][31:0];
          default: ;
        endcase
      end
    end
    if (raised) cfg_valid <= 1'b0;
  endtask

  // block is idle once every queued word went in and every hash came back;
  // any pending word restarts the quiet run, so a word just popped by the driver is not missed
  task automatic wait_idle();
    int quiet;
    quiet = 0;
    while (quiet < 2) begin
      @(posedge clk);
      if (sector_queries.size() != 0 || start || hashes_due.size() != 0) quiet = 0;
      else quiet++;
    end
  endtask

  // stimulus sequencing
  initial begin
    logic [63:0]        seed;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [2:0]         mask;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed words under reset register values
    sector_queries.push_back(make_query(ACT_HASH, '0, '0, '0, 8'd0, 32'd0, 32'd0));
    sector_queries.push_back(make_query(ACT_HASH, '1, '1, '1, 8'hFF, '1, '1));
    sector_queries.push_back(make_query(ACT_HASH, S64_MIN, S64_MAX, '0, 8'd0, 32'd0, '1));
    sector_queries.push_back(make_query(ACT_HASH, S64_MAX, S64_MIN, '1, 8'hFF, '1, 32'd0));
    sector_queries.push_back(make_query(ACT_HASH, 64'd1, '1, 64'd2, 8'd1, 32'd1, 32'd1));
    sector_queries.push_back(make_query(ACT_BODY, '0, '0, '0, 8'd0, 32'd0, 32'd0));
    sector_queries.push_back(make_query(ACT_BODY, '1, '1, '1, 8'hFF, $urandom, $urandom));
    sector_queries.push_back(make_query(ACT_BODY, '1, 64'd7, S64_MIN, 8'h80, 32'd0, '1));
    // same hash as the body-count word above
    sector_queries.push_back(make_query(ACT_HASH, '1, 64'd7, S64_MIN, 8'h80, '1, 32'd0));
    wait_idle();

    for (int p = 1; p <= PHASES; p++) begin
      seed = {$urandom, $urandom};
      mask = 3'b111;
      case (p)
        1: begin seed = '0; lo = S32_MIN; hi = S32_MAX; end
        2: begin seed = '1; lo = 32'sd5; hi = 32'sd5; end
        3: begin lo = 32'sd100; hi = -32'sd100; end
        4: begin lo = -32'sd50; hi = -32'sd60; end
        5: begin lo = S32_MAX; hi = S32_MAX; end
        6: begin lo = S32_MIN; hi = S32_MIN; end
        7: begin lo = 32'sd0; hi = 32'sd1; end
        8: begin lo = -32'sd1; hi = 32'sd0; end
        9: begin
          lo = $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
          hi = lo + $signed(32'($urandom_range(1, 1000)));
        end
        default: begin
          lo   = $urandom;
          hi   = $urandom;
          mask = 3'($urandom_range(1, 7));
        end
      endcase
      program_regs(seed, lo, hi, mask);

      // widest range: all-zero and extreme command words, plus one random word
      if (p == 1) begin
        sector_queries.push_back(make_query(ACT_BODY, '0, '0, '0, 8'd0, 32'd0, 32'd0));
        sector_queries.push_back(make_query(ACT_BODY, S64_MIN, S64_MAX, '1, 8'hFF, '1, '1));
        sector_queries.push_back(make_query(ACT_BODY, S64_MAX, S64_MIN, '0, 8'd3, '0, '0));
        sector_queries.push_back(rand_query());
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) sector_queries.push_back(rand_query());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && hashes_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // driver: one command word per start, random gaps with idle-free stretches
  sector_query_t cur_query;
  int            gap_left     = 0;
  int            no_idle_left = 0;
  int            roll;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        hashes_due.push_back(hash_query(cur_query));
        if (no_idle_left > 0) begin
          no_idle_left--;
          gap_left = 0;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 5) no_idle_left = $urandom_range(20, 60);
          if (roll < 50) gap_left = 0;
          else if (roll < 85) gap_left = $urandom_range(1, 3);
          else if (roll < 97) gap_left = $urandom_range(4, 10);
          else gap_left = $urandom_range(20, 60);
        end
      end
      // hold the word while the block is busy
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (sector_queries.size() > 0) begin
          cur_query = sector_queries.pop_front();
          action       <= cur_query.act;
          sector_x     <= cur_query.x;
          sector_y     <= cur_query.y;
          sector_z     <= cur_query.z;
          family       <= cur_query.fam;
          object_index <= cur_query.obj_index;
          property_req <= cur_query.prop;
          start        <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result word with the oldest predicted hash
  seed_result_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (hashes_due.size() == 0) begin
        $error("result word with no hash pending");
        failures++;
      end else begin
        want = hashes_due.pop_front();
        if (hash_value !== want.hash) begin
          $error("hash_value: expected %h, got %h", want.hash, hash_value);
          failures++;
        end
        if (unit_fraction !== want.frac) begin
          $error("unit_fraction: expected %h, got %h", want.frac, unit_fraction);
          failures++;
        end
        if (body_count !== want.count) begin
          $error("body_count: expected %0d, got %0d", want.count, body_count);
          failures++;
        end
      end
    end
  end

  // watchdog: stop if no word moves on any channel for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/csh_pkg.sv
rtl/csh_mix.sv
rtl/csh_fold_cell.sv
rtl/coordinate_seed_hasher_top.sv
bench/tb.sv
